FILE: rtl/lpht_pkg.sv
// Shared types, codes and constants for the linear-probing hash table.
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int NUM_W           = 34;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_EMIT
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [NUM_W-1:0]   phone_number;
    } in_word_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] slot_index;
    } out_word_t;

    typedef struct packed {
        logic    clear_wr;
        logic    load_in;
        logic    set_addr;
        logic    probe;
        logic    wr_ins;
        logic    latch_res;
        status_t res_status;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic live;
        logic empty;
        logic match;
        logic last;
        logic search;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lpht_datapath.sv
// Datapath: slot memory, home-slot hash, probe address walk and result registers.
`default_nettype none

module lpht_datapath #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lpht_pkg::in_word_t  in_word,
    input  wire lpht_pkg::cmd_t      cmd,
    output lpht_pkg::sts_t           sts,
    output lpht_pkg::out_word_t      out_word
);
    import lpht_pkg::*;

    localparam int             AW        = $clog2(TABLE_SLOTS);
    localparam int             MW        = NUM_W + 1;
    localparam logic [AW-1:0]  LAST_SLOT = AW'(TABLE_SLOTS - 1);

    logic [MW-1:0]    mem [TABLE_SLOTS];
    logic [MW-1:0]    rd_data_reg;

    action_t          op_reg;
    logic [NUM_W-1:0] num_reg;

    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    logic [AW-1:0]    data_pos_reg;
    logic [AW-1:0]    checked_reg;
    logic             live_reg;

    logic [AW-1:0]    home;
    logic             hash_done;

    status_t          pend_status_reg;
    logic [3:0]       pend_slot_reg;
    out_word_t        out_word_reg;
    logic [AW+3:0]    pos_ext;

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0)
        begin : g_mask
            assign home      = num_reg[AW-1:0];
            assign hash_done = 1'b1;
        end
        else
        begin : g_recip
            // fold the high half, reciprocal multiply, one correction
            localparam int            HALF     = NUM_W / 2;
            localparam int            YW       = NUM_W - HALF + AW;
            localparam logic [AW:0]   MOD      = (AW + 1)'(TABLE_SLOTS);
            localparam logic [YW-1:0] MOD_Y    = YW'(TABLE_SLOTS);
            localparam logic [YW-1:0] FOLD_C   = YW'((64'd1 << HALF) % TABLE_SLOTS);
            localparam logic [YW-1:0] RECIP    = YW'((64'd1 << YW) / TABLE_SLOTS);
            localparam logic [2:0]    HASH_CYC = 3'd4;

            logic [YW-1:0]   fold_reg;
            logic [YW-1:0]   quot_reg;
            logic [AW:0]     part_reg;
            logic [AW-1:0]   rem_reg;
            logic [2:0]      wait_reg;
            logic [2*YW-1:0] prod;

            assign prod = (2 * YW)'(fold_reg) * (2 * YW)'(RECIP);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    wait_reg <= '0;
                end
                else if (cmd.load_in)
                begin
                    wait_reg <= HASH_CYC;
                end
                else if (wait_reg != '0)
                begin
                    wait_reg <= wait_reg - 3'd1;
                end
            end

            always_ff @(posedge clk)
            begin
                fold_reg <= YW'(num_reg[NUM_W-1:HALF]) * FOLD_C + YW'(num_reg[HALF-1:0]);
                quot_reg <= prod[2*YW-1:YW];
                part_reg <= (AW + 1)'(fold_reg - YW'(quot_reg * MOD_Y));
                rem_reg  <= (part_reg >= MOD) ? AW'(part_reg - MOD) : part_reg[AW-1:0];
            end

            assign home      = rem_reg;
            assign hash_done = (wait_reg == '0);
        end
    endgenerate

    assign addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            live_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            live_reg <= cmd.probe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= in_word.action;
            num_reg <= in_word.phone_number;
        end
        if (cmd.set_addr)
        begin
            addr_reg    <= home;
            checked_reg <= '0;
        end
        else if (cmd.probe)
        begin
            addr_reg     <= addr_next;
            data_pos_reg <= addr_reg;
            if (live_reg)
            begin
                checked_reg <= checked_reg + AW'(1);
            end
        end
        if (cmd.latch_res)
        begin
            pend_status_reg <= cmd.res_status;
            pend_slot_reg   <= ((cmd.res_status == ST_INSERTED) ||
                                (cmd.res_status == ST_FOUND)) ? pos_ext[3:0] : 4'b0000;
        end
        if (cmd.emit)
        begin
            out_word_reg.status     <= pend_status_reg;
            out_word_reg.slot_index <= pend_slot_reg;
        end
    end

    // slot memory: {valid, number}
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_reg] <= '0;
        end
        else if (cmd.wr_ins)
        begin
            mem[data_pos_reg] <= {1'b1, num_reg};
        end
        if (cmd.probe)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign pos_ext = {4'b0000, data_pos_reg};

    assign sts.clr_last  = (clr_reg == LAST_SLOT);
    assign sts.hash_done = hash_done;
    assign sts.live      = live_reg;
    assign sts.empty     = !rd_data_reg[NUM_W];
    assign sts.match     = rd_data_reg[NUM_W] && (rd_data_reg[NUM_W-1:0] == num_reg);
    assign sts.last      = (checked_reg == LAST_SLOT);
    assign sts.search    = (op_reg == ACT_SEARCH);

    assign out_word = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/lpht_ctrl.sv
// Controller: clearing pass, hash wait, probe decisions and output handshake.
`default_nettype none

module lpht_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire lpht_pkg::sts_t sts,
    output lpht_pkg::cmd_t      cmd
);
    import lpht_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    logic    out_valid_reg;
    logic    out_free;
    logic    fin;
    status_t res_status;

    assign out_free = !out_valid_reg || out_ready;

    // probe ends on empty slot, search hit or full lap
    always_comb
    begin
        fin = sts.live && (sts.empty || (sts.search && sts.match) || sts.last);
        if (sts.search)
        begin
            res_status = sts.match ? ST_FOUND : ST_NOT_FOUND;
        end
        else
        begin
            res_status = sts.empty ? ST_INSERTED : ST_FULL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (fin)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_HASH:
            begin
                cmd.set_addr = sts.hash_done;
            end
            S_PROBE:
            begin
                if (fin)
                begin
                    cmd.latch_res  = 1'b1;
                    cmd.res_status = res_status;
                    cmd.wr_ins     = !sts.search && sts.empty;
                end
                else
                begin
                    cmd.probe = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.emit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HASH))
        else $error("accepted word did not start hashing");

    a_live_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        sts.live |-> (state_reg == S_PROBE))
        else $error("probe data live outside probing");

    a_write_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_ins |-> (sts.live && sts.empty && !sts.search))
        else $error("insert write without an empty slot");

    a_no_emit_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.emit)
        else $error("result overwrote a held output word");
`endif

endmodule

`default_nettype wire

FILE: rtl/linear_probe_hash_table.sv
// Top level: linear-probing hash table of telephone numbers.
// Home slot: a bit mask when TABLE_SLOTS is a power of two, else a registered reciprocal
// modulo. Each word probes 1 to TABLE_SLOTS slots; the probe reads one slot per cycle.
// A new word is taken only after the previous result has moved to the output register.
// Reset: a clearing pass over every slot of the slot memory with in_ready low, then idle.
// The output register holds a finished result while the next word is taken.
`default_nettype none

module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lpht_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lpht_pkg::out_word_t      out_word
);
    import lpht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_word)
    );

endmodule

`default_nettype wire

FILE: test/linear_probe_hash_table_tb.sv
// Testbench for linear_probe_hash_table: randomized insert/search traffic checked against a shadow table.
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;

    import lpht_pkg::*;

    localparam int SLOTS      = TABLE_SLOTS_DEF;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 400;
    localparam int RANDOM_CNT = 830;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;

    linear_probe_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    in_word_t    pending_requests[$];
    out_word_t   expected_replies[$];
    logic [33:0] shadow_num[SLOTS];
    logic        shadow_used[SLOTS];

    int  accepted_count = 0;
    int  total_count = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  in_taken = 1'b0;
    bit  hold_off = 1'b0;
    int  in_gap = 0;
    int  in_steady = 0;
    int  out_stall = 0;
    int  out_steady = 0;

    function automatic out_word_t lookup_or_store(in_word_t w);
        out_word_t   r;
        int unsigned pos;
        int unsigned seen;
        r.status     = (w.action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        r.slot_index = '0;
        pos  = int'(w.phone_number % SLOTS);
        seen = 0;
        while (seen < SLOTS && shadow_used[pos])
        begin
            if (w.action == ACT_SEARCH && shadow_num[pos] == w.phone_number)
            begin
                r.status     = ST_FOUND;
                r.slot_index = 4'(pos);
                return r;
            end
            pos  = (pos + 1) % SLOTS;
            seen = seen + 1;
        end
        if (w.action == ACT_INSERT && seen < SLOTS)
        begin
            shadow_num[pos]  = w.phone_number;
            shadow_used[pos] = 1'b1;
            r.status         = ST_INSERTED;
            r.slot_index     = 4'(pos);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [33:0] rand_number();
        return {2'($urandom_range(0, 3)), 32'($urandom)};
    endfunction

    task automatic queue_request(action_t a, logic [33:0] n);
        in_word_t w;
        w.action       = a;
        w.phone_number = n;
        pending_requests.push_back(w);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                in_word  <= pending_requests.pop_front();
                in_valid <= 1'b1;
                if (hold_off)
                    in_gap = 0;
                else if (in_steady > 0)
                begin
                    in_steady = in_steady - 1;
                    in_gap    = 0;
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    in_steady = $urandom_range(20, 60);
                    in_gap    = 0;
                end
                else
                    in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output ready driver
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall = out_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_steady > 0)
                out_steady = out_steady - 1;
            else if ($urandom_range(0, 49) == 0)
                out_steady = $urandom_range(20, 80);
            else
                out_stall = pick_gap();
        end
    end

    // accepted input words feed the shadow table
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_replies.push_back(lookup_or_store(in_word));
            accepted_count = accepted_count + 1;
            in_taken = 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_word_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, out_word);
                error_count = error_count + 1;
            end
            else
            begin
                exp_word = expected_replies.pop_front();
                if (out_word.status !== exp_word.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_word.status, out_word.status);
                    error_count = error_count + 1;
                end
                if (out_word.slot_index !== exp_word.slot_index)
                begin
                    $display("%0t: slot_index mismatch, expected %0d actual %0d",
                             $time, exp_word.slot_index, out_word.slot_index);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t: timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (accepted_count >= 120);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        logic [33:0] stored[$];
        logic [33:0] n;
        int          pick;

        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_num[i]  = '0;
            shadow_used[i] = 1'b0;
        end

        queue_request(ACT_SEARCH, 34'd0);               // empty table
        queue_request(ACT_INSERT, 34'd0);
        queue_request(ACT_INSERT, 34'd0);               // duplicate
        queue_request(ACT_SEARCH, 34'd0);
        queue_request(ACT_INSERT, 34'd16);              // collides at home
        queue_request(ACT_SEARCH, 34'd16);
        queue_request(ACT_SEARCH, 34'd32);              // miss ends at empty slot
        queue_request(ACT_INSERT, 34'h3_FFFF_FFFF);     // above ten digits, last slot
        queue_request(ACT_INSERT, 34'd15);              // wraps around
        queue_request(ACT_SEARCH, 34'd15);
        queue_request(ACT_INSERT, 34'd9999999999);
        queue_request(ACT_SEARCH, 34'h3_FFFF_FFFF);
        queue_request(ACT_INSERT, 34'h2_AAAA_AAAA);
        queue_request(ACT_INSERT, 34'h1_5555_5555);
        queue_request(ACT_SEARCH, 34'h1_5555_5555);
        queue_request(ACT_SEARCH, 34'd9999999999);
        queue_request(ACT_SEARCH, 34'h2_AAAA_AAAB);
        stored = '{34'd0, 34'd0, 34'd16, 34'h3_FFFF_FFFF, 34'd15,
                   34'd9999999999, 34'h2_AAAA_AAAA, 34'h1_5555_5555};

        for (int i = 0; i < RANDOM_CNT; i++)
        begin
            if ($urandom_range(0, (stored.size() < SLOTS) ? 19 : 5) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    n = rand_number();
                else if (pick < 7)
                    n = stored[$urandom_range(0, stored.size() - 1)];
                else
                    n = stored[$urandom_range(0, stored.size() - 1)] ^ (rand_number() << 4);
                queue_request(ACT_INSERT, n);
                if (stored.size() < SLOTS)
                    stored.push_back(n);
            end
            else
            begin
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    n = stored[$urandom_range(0, stored.size() - 1)];
                else if (pick == 2)
                    n = stored[$urandom_range(0, stored.size() - 1)]
                        + 34'(SLOTS * $urandom_range(1, 1000));
                else
                    n = rand_number();
                queue_request(ACT_SEARCH, n);
            end
        end
        total_count = pending_requests.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_count)
            @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
        repeat (4 * SLOTS + 40) @(posedge clk);

        if (error_count == 0 && expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/lpht_pkg.sv
rtl/lpht_datapath.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_tb.sv
